// ----- hw/rtl/qvr_pkg.sv -----
package qvr_pkg;

	localparam int DataW = 16;
	localparam int NumW  = 53;
	localparam int DenW  = 35;
	localparam int QuoW  = 17;

	typedef logic signed [DataW-1:0] data_t;

	typedef struct packed {
		logic [2:0][NumW-1:0] num;
		logic [DenW-1:0]      den;
		logic [2:0]           neg;
		logic                 err;
	} qvr_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qvr_fifo_stat_t;

endpackage

// ----- hw/rtl/qvr_front.sv -----
module qvr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  qvr_pkg::data_t   quat_w,
	input  qvr_pkg::data_t   quat_x,
	input  qvr_pkg::data_t   quat_y,
	input  qvr_pkg::data_t   quat_z,
	input  qvr_pkg::data_t   vec_x,
	input  qvr_pkg::data_t   vec_y,
	input  qvr_pkg::data_t   vec_z,
	output logic             word_valid,
	output qvr_pkg::qvr_word_t word
);
	import qvr_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [31:0] c1_s1, c2_s1, c3_s1, c4_s1, c5_s1, c6_s1;
	logic signed [16:0] w2_s1, w2_s2;
	data_t vx_s1, vy_s1, vz_s1, ux_s1, uy_s1, uz_s1;

	logic signed [34:0] ns_s2, s_s2, d2_s2, ns_s3;
	logic signed [32:0] cx_s2, cy_s2, cz_s2;
	data_t vx_s2, vy_s2, vz_s2, ux_s2, uy_s2, uz_s2;

	logic signed [50:0] ps_s3 [3], pd_s3 [3], pw_s3 [3];

	logic signed [52:0] n_c [3];
	logic [NumW-1:0] mag_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ww_s1 <= quat_w * quat_w;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		dx_s1 <= quat_x * vec_x;
		dy_s1 <= quat_y * vec_y;
		dz_s1 <= quat_z * vec_z;
		c1_s1 <= quat_y * vec_z;
		c2_s1 <= quat_z * vec_y;
		c3_s1 <= quat_z * vec_x;
		c4_s1 <= quat_x * vec_z;
		c5_s1 <= quat_x * vec_y;
		c6_s1 <= quat_y * vec_x;
		w2_s1 <= {quat_w, 1'b0};
		vx_s1 <= vec_x;
		vy_s1 <= vec_y;
		vz_s1 <= vec_z;
		ux_s1 <= quat_x;
		uy_s1 <= quat_y;
		uz_s1 <= quat_z;

		ns_s2 <= 35'(ww_s1) + 35'(xx_s1) + 35'(yy_s1) + 35'(zz_s1);
		s_s2  <= 35'(ww_s1) - 35'(xx_s1) - 35'(yy_s1) - 35'(zz_s1);
		d2_s2 <= (35'(dx_s1) + 35'(dy_s1) + 35'(dz_s1)) <<< 1;
		cx_s2 <= 33'(c1_s1) - 33'(c2_s1);
		cy_s2 <= 33'(c3_s1) - 33'(c4_s1);
		cz_s2 <= 33'(c5_s1) - 33'(c6_s1);
		w2_s2 <= w2_s1;
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		vz_s2 <= vz_s1;
		ux_s2 <= ux_s1;
		uy_s2 <= uy_s1;
		uz_s2 <= uz_s1;

		ps_s3[0] <= s_s2 * vx_s2;
		ps_s3[1] <= s_s2 * vy_s2;
		ps_s3[2] <= s_s2 * vz_s2;
		pd_s3[0] <= d2_s2 * ux_s2;
		pd_s3[1] <= d2_s2 * uy_s2;
		pd_s3[2] <= d2_s2 * uz_s2;
		pw_s3[0] <= w2_s2 * cx_s2;
		pw_s3[1] <= w2_s2 * cy_s2;
		pw_s3[2] <= w2_s2 * cz_s2;
		ns_s3 <= ns_s2;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i]   = 53'(ps_s3[i]) + 53'(pd_s3[i]) + 53'(pw_s3[i]);
			mag_c[i] = n_c[i][52] ? NumW'(-n_c[i]) : NumW'(n_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			word.num[i] <= (mag_c[i] << 1) + NumW'(ns_s3);
			word.neg[i] <= n_c[i][52];
		end
		word.den <= DenW'(ns_s3) << 1;
		word.err <= (ns_s3 == '0);
	end

	assign word_valid = valid_s4;

endmodule

// ----- hw/rtl/qvr_fifo.sv -----
module qvr_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  qvr_pkg::qvr_word_t    push_word,
	output logic                  pop_valid,
	output qvr_pkg::qvr_word_t    pop_word,
	output qvr_pkg::qvr_fifo_stat_t stat
);
	import qvr_pkg::*;

	qvr_word_t mem_q [2];
	logic [1:0] vld_q;
	logic wr_q, rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (vld_q[rd_q]) begin
				vld_q[rd_q] <= 1'b0;
				rd_q        <= ~rd_q;
			end
			if (push) begin
				vld_q[wr_q] <= 1'b1;
				wr_q        <= ~wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	assign pop_valid  = vld_q[rd_q];
	assign pop_word   = mem_q[rd_q];
	assign stat.full  = &vld_q;
	assign stat.empty = ~|vld_q;

endmodule

// ----- hw/rtl/qvr_back.sv -----
module qvr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               word_valid,
	input  qvr_pkg::qvr_word_t word,
	output logic               done,
	output qvr_pkg::data_t     out_x,
	output qvr_pkg::data_t     out_y,
	output qvr_pkg::data_t     out_z,
	output logic               zero_norm_error
);
	import qvr_pkg::*;

	logic [QuoW:0]              vld_s;
	logic [2:0][NumW-1:0]       rem_s [QuoW+1];
	logic [2:0][QuoW-1:0]       quo_s [QuoW+1];
	logic [2:0]                 ovf_s [QuoW+1];
	logic [2:0]                 neg_s [QuoW+1];
	logic [DenW-1:0]            den_s [QuoW+1];
	logic                       err_s [QuoW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[QuoW-1:0], word_valid};
			done  <= vld_s[QuoW];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= word.num[i];
			ovf_s[0][i] <= word.num[i] >= (NumW'(word.den) << QuoW);
		end
		quo_s[0] <= '0;
		neg_s[0] <= word.neg;
		den_s[0] <= word.den;
		err_s[0] <= word.err;
	end

	for (genvar k = 1; k <= QuoW; k++) begin : g_div
		localparam int Sh = QuoW - k;
		logic [NumW-1:0] dsh;
		assign dsh = NumW'(den_s[k-1]) << Sh;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_s[k-1][i] >= dsh) begin
					rem_s[k][i]     <= rem_s[k-1][i] - dsh;
					quo_s[k][i]     <= quo_s[k-1][i] | (QuoW'(1) << Sh);
				end else begin
					rem_s[k][i]     <= rem_s[k-1][i];
					quo_s[k][i]     <= quo_s[k-1][i];
				end
			end
			ovf_s[k] <= ovf_s[k-1];
			neg_s[k] <= neg_s[k-1];
			den_s[k] <= den_s[k-1];
			err_s[k] <= err_s[k-1];
		end
	end

	data_t res_c [3];
	logic [QuoW-1:0] q_c;

	always_comb begin
		q_c = '0;
		for (int i = 0; i < 3; i++) begin
			q_c = quo_s[QuoW][i];
			if (err_s[QuoW]) begin
				res_c[i] = '0;
			end else if (neg_s[QuoW][i]) begin
				if (ovf_s[QuoW][i] || q_c > QuoW'(32768)) begin
					res_c[i] = 16'sh8000;
				end else begin
					res_c[i] = DataW'(-q_c);
				end
			end else begin
				if (ovf_s[QuoW][i] || q_c > QuoW'(32767)) begin
					res_c[i] = 16'sh7fff;
				end else begin
					res_c[i] = DataW'(q_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		out_x           <= res_c[0];
		out_y           <= res_c[1];
		out_z           <= res_c[2];
		zero_norm_error <= err_s[QuoW];
	end

endmodule

// ----- hw/rtl/quaternion_vector_rotate.sv -----
// Channel  | Ports                                   | Handshake
// input    | quat_w..quat_z, vec_x..vec_z            | start high, busy low
// result   | out_x, out_y, out_z, zero_norm_error    | done strobe, one cycle
// One word is accepted every cycle while busy is low; its result shows with the done strobe.
// The front computes the rotation numerator and squared norm in four stages.
// The word then passes through the queue, and the back checks for overflow in one stage.
// The back then finds one quotient bit per stage over seventeen stages and registers the result.
// Reset clears all valid flags; busy stays low since the back never stalls.
module quaternion_vector_rotate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qvr_pkg::data_t quat_w,
	input  qvr_pkg::data_t quat_x,
	input  qvr_pkg::data_t quat_y,
	input  qvr_pkg::data_t quat_z,
	input  qvr_pkg::data_t vec_x,
	input  qvr_pkg::data_t vec_y,
	input  qvr_pkg::data_t vec_z,
	output logic           done,
	output qvr_pkg::data_t out_x,
	output qvr_pkg::data_t out_y,
	output qvr_pkg::data_t out_z,
	output logic           zero_norm_error
);
	import qvr_pkg::*;

	logic           front_valid, back_valid;
	qvr_word_t      front_word, back_word;
	qvr_fifo_stat_t fifo_stat;

	assign busy = fifo_stat.full;

	qvr_front u_front (
		.clk, .arst_n,
		.in_valid(start && !busy),
		.quat_w, .quat_x, .quat_y, .quat_z,
		.vec_x, .vec_y, .vec_z,
		.word_valid(front_valid),
		.word(front_word)
	);

	qvr_fifo u_fifo (
		.clk, .arst_n,
		.push(front_valid),
		.push_word(front_word),
		.pop_valid(back_valid),
		.pop_word(back_word),
		.stat(fifo_stat)
	);

	qvr_back u_back (
		.clk, .arst_n,
		.word_valid(back_valid),
		.word(back_word),
		.done, .out_x, .out_y, .out_z, .zero_norm_error
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_norm_error |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("zero norm result is not zero");

	a_fifo_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_stat.full)
		else $error("queue filled although the back never stalls");

	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.empty |-> !back_valid)
		else $error("queue pops while empty");

endmodule
